### rtl/flpte_pkg.sv
// Shared constants, codes and control types of the four-level page table engine.
package flpte_pkg;

  localparam int TABLE_COUNT_DEF   = 64;
  localparam int ENTRY_W           = 64;
  localparam int IDX_W             = 9;
  localparam int PAGE_SHIFT        = 12;
  localparam int VA_W              = 48;
  localparam int PA_W              = 52;
  localparam int FLAGS_W           = 12;
  localparam int FRAME_W           = PA_W - PAGE_SHIFT;
  localparam int ROOT_W            = 6;
  localparam int LVL_W             = 2;
  localparam int CMD_W             = 2;
  localparam int STATUS_W          = 2;
  localparam int L0_SHIFT          = 39;
  localparam int L1_SHIFT          = 30;
  localparam int L2_SHIFT          = 21;
  localparam int L3_SHIFT          = 12;
  localparam int BIT_PRESENT       = 0;
  localparam int BIT_WRITABLE      = 1;
  localparam int BIT_USER          = 2;
  localparam int MOD_BITS_PER_STEP = 8;

  localparam logic [LVL_W-1:0] LVL_TOP  = 2'd0;
  localparam logic [LVL_W-1:0] LVL_MID  = 2'd1;
  localparam logic [LVL_W-1:0] LVL_DIR  = 2'd2;
  localparam logic [LVL_W-1:0] LVL_LEAF = 2'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_MAP     = 2'd0,
    CMD_UNMAP   = 2'd1,
    CMD_RESOLVE = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK            = 2'd0,
    STS_OUT_OF_TABLES = 2'd1,
    STS_NOT_MAPPED    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_MOD,
    ST_CHECK,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic adv_short;
    logic mod_start;
    logic adv_mod;
    logic wr;
    logic set_oot;
    logic set_nm;
    logic set_res;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic             clr_done;
    logic             present;
    logic             small_child;
    logic             mod_busy;
    logic             mod_done;
    logic [LVL_W-1:0] lvl;
    cmd_t             cmd;
    logic             pool_short;
    logic             out_busy;
  } dp_stat_t;

endpackage

### rtl/flpte_ram.sv
// Generic single-port RAM with registered read data.
module flpte_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/flpte_mod.sv
// Multi-cycle reduction of a table frame field modulo the pool size.
module flpte_mod import flpte_pkg::*; #(
  parameter int TABLE_COUNT = TABLE_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [FRAME_W-1:0]             value,
  output logic                           busy,
  output logic                           done,
  output logic [$clog2(TABLE_COUNT)-1:0] rem
);

  localparam int TW    = $clog2(TABLE_COUNT);
  localparam int STEPS = FRAME_W / MOD_BITS_PER_STEP;
  localparam int CW    = $clog2(STEPS);

  logic [FRAME_W-1:0] val_r;
  logic [FRAME_W-1:0] val_nxt;
  logic [TW:0]        rem_r;
  logic [TW:0]        rem_nxt;
  logic [CW-1:0]      cnt_r;
  logic               busy_r;
  logic               done_r;

  // shift in one byte of the value, MSB first, with a conditional subtract per bit
  always_comb begin
    rem_nxt = rem_r;
    for (int i = 0; i < MOD_BITS_PER_STEP; i++) begin
      rem_nxt = {rem_nxt[TW-1:0], val_r[FRAME_W-1-i]};
      if (rem_nxt >= (TW+1)'(TABLE_COUNT)) begin
        rem_nxt = rem_nxt - (TW+1)'(TABLE_COUNT);
      end
    end
    val_nxt = val_r << MOD_BITS_PER_STEP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r <= value;
      rem_r <= '0;
    end else if (busy_r) begin
      val_r <= val_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign rem  = rem_r[TW-1:0];

endmodule

### rtl/flpte_datapath.sv
// Datapath: request and walk registers, table memory, allocator and result register.
module flpte_datapath import flpte_pkg::*; #(
  parameter int TABLE_COUNT = TABLE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd_i,
  output dp_stat_t            stat_o,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [VA_W-1:0]     in_virt_addr,
  input  logic [PA_W-1:0]     in_phys_addr,
  input  logic [FLAGS_W-1:0]  in_page_flags,
  input  logic                cfg_wr_en,
  input  logic [ROOT_W-1:0]   cfg_wr_data,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [PA_W-1:0]     out_resolved_addr,
  output logic                out_flush_tlb
);

  localparam int TW    = $clog2(TABLE_COUNT);
  localparam int NW    = $clog2(TABLE_COUNT + 1);
  localparam int AW    = TW + IDX_W;
  localparam int DEPTH = TABLE_COUNT * (1 << IDX_W);

  logic [ROOT_W-1:0]  root_r;
  cmd_t               req_cmd_r;
  logic [VA_W-1:0]    va_r;
  logic [PA_W-1:0]    pa_r;
  logic [FLAGS_W-1:0] flags_r;
  logic [LVL_W-1:0]   lvl_r;
  logic [TW-1:0]      t_r;
  logic [NW-1:0]      nfree_r;
  logic [AW-1:0]      clr_cnt_r;
  status_t            res_status_r;
  logic [PA_W-1:0]    res_addr_r;
  logic               res_flush_r;
  logic               out_valid_r;
  status_t            out_status_r;
  logic [PA_W-1:0]    out_addr_r;
  logic               out_flush_r;

  logic [IDX_W-1:0]   idx;
  logic [AW-1:0]      ram_addr;
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ENTRY_W-1:0] wr_data;
  logic [FRAME_W-1:0] frame;
  logic               mod_busy;
  logic               mod_done;
  logic [TW-1:0]      mod_rem;
  logic [NW+1:0]      pool_need;
  logic [TW-1:0]      root_mod [2**ROOT_W];

  // root index reduced modulo the pool size, worked out at elaboration
  for (genvar gi = 0; gi < 2**ROOT_W; gi++) begin : g_root_mod
    assign root_mod[gi] = TW'(gi % TABLE_COUNT);
  end

  always_comb begin
    unique case (lvl_r)
      LVL_TOP:  idx = va_r[L0_SHIFT +: IDX_W];
      LVL_MID:  idx = va_r[L1_SHIFT +: IDX_W];
      LVL_DIR:  idx = va_r[L2_SHIFT +: IDX_W];
      LVL_LEAF: idx = va_r[L3_SHIFT +: IDX_W];
      default:  idx = va_r[L3_SHIFT +: IDX_W];
    endcase
  end

  // entry written by a map or unmap step
  always_comb begin
    wr_data = '0;
    if (req_cmd_r == CMD_MAP) begin
      if (lvl_r == LVL_LEAF) begin
        wr_data[PAGE_SHIFT +: FRAME_W] = pa_r[PA_W-1:PAGE_SHIFT];
        wr_data[FLAGS_W-1:0]           = flags_r;
        wr_data[BIT_PRESENT]           = 1'b1;
      end else begin
        wr_data[PAGE_SHIFT +: NW] = nfree_r;
        wr_data[BIT_PRESENT]      = 1'b1;
        wr_data[BIT_WRITABLE]     = 1'b1;
        wr_data[BIT_USER]         = flags_r[BIT_USER];
      end
    end
  end

  assign ram_addr  = cmd_i.clr_wr ? clr_cnt_r : {t_r, idx};
  assign ram_we    = cmd_i.clr_wr | cmd_i.wr;
  assign ram_wdata = cmd_i.clr_wr ? '0 : wr_data;
  assign frame     = ram_rdata[PAGE_SHIFT +: FRAME_W];
  assign pool_need = {2'b00, nfree_r} + (NW+2)'(LVL_LEAF - lvl_r);

  flpte_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  flpte_mod #(
    .TABLE_COUNT (TABLE_COUNT)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd_i.mod_start),
    .value (frame),
    .busy  (mod_busy),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r      <= '0;
      nfree_r     <= NW'(1);
      clr_cnt_r   <= '0;
      lvl_r       <= LVL_TOP;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        root_r <= cfg_wr_data;
      end
      if (cmd_i.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd_i.load) begin
        lvl_r <= LVL_TOP;
      end else if (cmd_i.adv_short || cmd_i.adv_mod) begin
        lvl_r <= lvl_r + 1'b1;
      end else if (cmd_i.wr && lvl_r != LVL_LEAF) begin
        lvl_r   <= lvl_r + 1'b1;
        nfree_r <= nfree_r + 1'b1;
      end
      if (cmd_i.push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      req_cmd_r    <= cmd_t'(in_cmd);
      va_r         <= in_virt_addr;
      pa_r         <= in_phys_addr;
      flags_r      <= in_page_flags;
      t_r          <= root_mod[root_r];
      res_status_r <= STS_OK;
      res_addr_r   <= '0;
      res_flush_r  <= 1'b0;
    end else begin
      if (cmd_i.adv_short) begin
        t_r <= frame[TW-1:0];
      end
      if (cmd_i.adv_mod) begin
        t_r <= mod_rem;
      end
      if (cmd_i.wr) begin
        if (lvl_r == LVL_LEAF) begin
          res_flush_r <= 1'b1;
        end else begin
          t_r <= nfree_r[TW-1:0];
        end
      end
      if (cmd_i.set_oot) begin
        res_status_r <= STS_OUT_OF_TABLES;
      end
      if (cmd_i.set_nm) begin
        res_status_r <= STS_NOT_MAPPED;
      end
      if (cmd_i.set_res) begin
        res_addr_r <= {frame, va_r[PAGE_SHIFT-1:0]};
      end
    end
    if (cmd_i.push) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_flush_r  <= res_flush_r;
    end
  end

  always_comb begin
    stat_o             = '0;
    stat_o.clr_done    = (clr_cnt_r == AW'(DEPTH - 1));
    stat_o.present     = ram_rdata[BIT_PRESENT];
    stat_o.small_child = (frame < FRAME_W'(TABLE_COUNT));
    stat_o.mod_busy    = mod_busy;
    stat_o.mod_done    = mod_done;
    stat_o.lvl         = lvl_r;
    stat_o.cmd         = req_cmd_r;
    stat_o.pool_short  = (pool_need > (NW+2)'(TABLE_COUNT));
    stat_o.out_busy    = out_valid_r & out_stall;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_resolved_addr = out_addr_r;
  assign out_flush_tlb     = out_flush_r;

endmodule

### rtl/flpte_ctrl.sv
// Controller state machine: sequences clearing, walks, allocation and result hand-off.
module flpte_ctrl import flpte_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMD_W-1:0] in_cmd,
  input  dp_stat_t         stat_i,
  output dp_cmd_t          cmd_o
);

  state_t state_r;
  state_t state_nxt;
  state_t after_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // where a walk goes once it has stepped down one level
  always_comb begin
    after_adv = ST_READ;
    if (stat_i.lvl == LVL_DIR) begin
      case (stat_i.cmd)
        CMD_MAP:   after_adv = ST_CHECK;
        CMD_UNMAP: after_adv = ST_WRITE;
        default:   after_adv = ST_READ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_nxt  = (cmd_t'(in_cmd) == CMD_NOP) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (stat_i.lvl == LVL_LEAF) begin
          if (stat_i.present) begin
            cmd_o.set_res = 1'b1;
          end else begin
            cmd_o.set_nm = 1'b1;
          end
          state_nxt = ST_DONE;
        end else if (!stat_i.present) begin
          // map builds from the missing level; the others give up
          if (stat_i.cmd == CMD_MAP) begin
            state_nxt = ST_CHECK;
          end else begin
            cmd_o.set_nm = 1'b1;
            state_nxt    = ST_DONE;
          end
        end else if (stat_i.small_child) begin
          cmd_o.adv_short = 1'b1;
          state_nxt       = after_adv;
        end else begin
          cmd_o.mod_start = 1'b1;
          state_nxt       = ST_MOD;
        end
      end
      ST_MOD: begin
        if (stat_i.mod_done) begin
          cmd_o.adv_mod = 1'b1;
          state_nxt     = after_adv;
        end
      end
      ST_CHECK: begin
        if (stat_i.pool_short) begin
          cmd_o.set_oot = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.wr = 1'b1;
        if (stat_i.lvl == LVL_LEAF) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the result register is free
        if (!stat_i.out_busy) begin
          cmd_o.push = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/four_level_page_table_engine.sv
// Four-level page table engine: map, unmap and resolve over a pool of 512-entry tables.
// After reset the block zeroes every entry of the table memory and
// stalls its input meanwhile; the root register can be written during that time. A
// request is worked through step by step, since every table access goes through the one
// single-port table memory: it is taken, the levels are read, a map checks the pool,
// a map or unmap writes entries, and the result is handed off to the result register.
// A level whose stored child field is at or above TABLE_COUNT also passes through the
// modulo unit. The result register lets the next request be taken while a result waits;
// that request's hand-off then holds until the waiting result is taken.
module four_level_page_table_engine import flpte_pkg::*; #(
  parameter int TABLE_COUNT = TABLE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [VA_W-1:0]     in_virt_addr,
  input  logic [PA_W-1:0]     in_phys_addr,
  input  logic [FLAGS_W-1:0]  in_page_flags,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [PA_W-1:0]     out_resolved_addr,
  output logic                out_flush_tlb,
  input  logic                cfg_wr_en,
  input  logic [ROOT_W-1:0]   cfg_wr_data
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  flpte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_cmd   (in_cmd),
    .stat_i   (dp_stat),
    .cmd_o    (dp_cmd)
  );

  flpte_datapath #(
    .TABLE_COUNT (TABLE_COUNT)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_i             (dp_cmd),
    .stat_o            (dp_stat),
    .in_cmd            (in_cmd),
    .in_virt_addr      (in_virt_addr),
    .in_phys_addr      (in_phys_addr),
    .in_page_flags     (in_page_flags),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_resolved_addr (out_resolved_addr),
    .out_flush_tlb     (out_flush_tlb)
  );

`ifndef NO_ASSERTIONS
  a_mod_latency: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.mod_start |-> ##6 dp_stat.mod_done)
    else $error("modulo unit did not finish on time");

  a_valid_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(dp_cmd.push))
    else $error("result appeared without a push");

  a_no_write_after_oot: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.set_oot |=> !dp_cmd.wr)
    else $error("table write after out of tables");

  a_stall_during_mod: assert property (@(posedge clk) disable iff (!rst_n)
    dp_stat.mod_busy |-> in_stall)
    else $error("request taken while a walk is reducing a child index");
`endif

endmodule
